/* sv/cpcg_pkg.sv */
// ----------------------------------------------------------------------------
// cpcg_pkg: shared types, constants and GF(2^8) helpers
// Holds the token that travels down the cell chain, the cell control word,
// the constant AES sequence tables and the field multiply.
// ----------------------------------------------------------------------------
package cpcg_pkg;

    localparam int PARITY_ROWS = 6;
    localparam int DISK_COUNT  = 257 - PARITY_ROWS;

    localparam logic [7:0] AES_POLY    = 8'h1b;
    localparam logic [7:0] RESET_POLY  = 8'h1d;
    localparam logic [7:0] RESET_GEN   = 8'h02;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_MATRIX_MODE    = 2'd0;
    localparam logic [1:0] CFG_REDUCTION_POLY = 2'd1;
    localparam logic [1:0] CFG_GENERATOR      = 2'd2;

    // Exponent whose power of a unit is its inverse for any degree-8 modulus:
    // the exponent of every possible unit group is 168661080.
    localparam int         INV_EXP_BITS = 28;
    localparam logic [INV_EXP_BITS-1:0] INV_EXP = 28'd168661079;

    localparam int POW_CELLS = 16;                 // disk index and row powers
    localparam int INV_CELLS = 2 * INV_EXP_BITS;   // one inversion pass

    typedef logic [7:0] byte_tab_t [256];
    typedef logic [7:0] ytab_t [8];

    typedef struct packed {
        logic       sq;
        logic       bit0;
        logic       bit1;
    } cell_ctl_t;

    typedef struct packed {
        logic       vld;
        logic       mode;
        logic [7:0] poly;
        logic [2:0] row;
        logic       rng;
        logic [7:0] ebits;
        logic [2:0] ebits1;
        logic [7:0] a;
        logic [7:0] y;
        logic [7:0] base0;
        logic [7:0] acc0;
        logic [7:0] base1;
        logic [7:0] acc1;
        logic [7:0] m0;
        logic [7:0] m1;
    } tok_t;

    function automatic logic [7:0] gf_mul(input logic [7:0] poly, input logic [7:0] a,
                                          input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'd0;
        x   = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                acc = acc ^ x;
            end
            if (x[7])
            begin
                x = {x[6:0], 1'b0} ^ poly;
            end
            else
            begin
                x = {x[6:0], 1'b0};
            end
        end
        return acc;
    endfunction

    function automatic byte_tab_t build_q();
        byte_tab_t  q;
        logic [7:0] m;
        q[0] = 8'd1;
        for (int k = 0; k < 254; k++)
        begin
            m = (k == 50 || k == 101 || k == 152 || k == 203) ? 8'd3 : 8'd2;
            q[k + 1] = gf_mul(AES_POLY, m, q[k]);
        end
        q[255] = 8'd0;
        return q;
    endfunction

    localparam byte_tab_t Q_TAB = build_q();

    function automatic ytab_t build_y();
        ytab_t      t;
        logic [7:0] v;
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            v = Q_TAB[(255 - k) % 255];
            r = 8'd1;
            for (int n = 0; n < 254; n++)
            begin
                r = gf_mul(AES_POLY, r, v);
            end
            t[k] = r;
        end
        return t;
    endfunction

    localparam ytab_t Y_TAB = build_y();

endpackage

/* sv/cpcg_pow_cell.sv */
// ----------------------------------------------------------------------------
// cpcg_pow_cell: one square-or-multiply step of two exponentiation lanes
// Each cell performs one field multiply per lane and hands the token on.
// ----------------------------------------------------------------------------
module cpcg_pow_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  cpcg_pkg::cell_ctl_t ctl,
    input  cpcg_pkg::tok_t    tok_in,
    output cpcg_pkg::tok_t    tok_out
);

    cpcg_pkg::tok_t tok_reg;
    cpcg_pkg::tok_t tok_next;
    logic [7:0]     opnd0;
    logic [7:0]     opnd1;

    always_comb
    begin
        opnd0 = ctl.sq ? tok_in.acc0 : (ctl.bit0 ? tok_in.base0 : 8'd1);
        opnd1 = ctl.sq ? tok_in.acc1 : (ctl.bit1 ? tok_in.base1 : 8'd1);
        tok_next      = tok_in;
        tok_next.acc0 = cpcg_pkg::gf_mul(tok_in.poly, tok_in.acc0, opnd0);
        tok_next.acc1 = cpcg_pkg::gf_mul(tok_in.poly, tok_in.acc1, opnd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (en)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* sv/cauchy_parity_coefficient_gen_core.sv */
// ----------------------------------------------------------------------------
// cauchy_parity_coefficient_gen_core: extended Cauchy coefficient generator
// Answers one entry of the normalised extended Cauchy generator matrix over
// GF(2^8) per transaction, in RAID or AES construction, with no stored matrix.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  request  | in_valid, in_stall, parity_row, disk_index | into core
//  result   | out_valid, out_stall, coefficient, in_range| out of core
//  config   | cfg_we, cfg_index, cfg_data                | into core
//
// One transaction is accepted per cycle while no stalled result holds the
// chain. A request passes through 16 cells for g^i and g^(r-1), two
// inversion passes of 56 cells each (a fixed power by square and
// multiply), a unit-check stage after each pass and the output register,
// which also forms the final product.
// Reset clears every token and loads the registers with RAID mode,
// polynomial 0x1d and generator 2. A stalled result holds the whole chain,
// so in_stall follows out_stall while a result waits.
//
module cauchy_parity_coefficient_gen_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] parity_row,
    input  logic [7:0] disk_index,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] coefficient,
    output logic       in_range,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic       mode_reg;
    logic [7:0] poly_reg;
    logic [7:0] gen_reg;

    logic       en;

    cpcg_pkg::tok_t tok_entry;
    cpcg_pkg::tok_t chain_a [cpcg_pkg::POW_CELLS + 1];
    cpcg_pkg::tok_t chain_b [cpcg_pkg::INV_CELLS + 1];
    cpcg_pkg::tok_t chain_c [cpcg_pkg::INV_CELLS + 1];
    cpcg_pkg::tok_t x_reg;
    cpcg_pkg::tok_t x_next;
    cpcg_pkg::tok_t m_reg;
    cpcg_pkg::tok_t m_next;

    logic       out_vld_reg;
    logic [7:0] coef_reg;
    logic [7:0] coef_next;
    logic       rng_reg;

    logic [7:0] e_val;
    logic [7:0] f_val;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            poly_reg <= cpcg_pkg::RESET_POLY;
            gen_reg  <= cpcg_pkg::RESET_GEN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cpcg_pkg::CFG_MATRIX_MODE:    mode_reg <= cfg_data[0];
                cpcg_pkg::CFG_REDUCTION_POLY: poly_reg <= cfg_data;
                cpcg_pkg::CFG_GENERATOR:      gen_reg  <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // The whole chain moves unless a finished result is held by the sink.
    assign en       = !(out_vld_reg && out_stall);
    assign in_stall = !en;

    // Entry token: the AES table values are looked up here and chosen after
    // the power cells, where the RAID values become available.
    always_comb
    begin
        tok_entry        = '0;
        tok_entry.vld    = in_valid;
        tok_entry.mode   = mode_reg;
        tok_entry.poly   = mode_reg ? cpcg_pkg::AES_POLY : poly_reg;
        tok_entry.row    = parity_row;
        tok_entry.rng    = (32'(parity_row) < cpcg_pkg::PARITY_ROWS) &&
                           (32'(disk_index) < cpcg_pkg::DISK_COUNT);
        tok_entry.ebits  = disk_index;
        tok_entry.ebits1 = parity_row - 3'd1;
        tok_entry.a      = cpcg_pkg::Q_TAB[disk_index];
        tok_entry.y      = cpcg_pkg::Y_TAB[parity_row - 3'd1];
        tok_entry.base0  = gen_reg;
        tok_entry.acc0   = 8'd1;
        tok_entry.base1  = gen_reg;
        tok_entry.acc1   = 8'd1;
    end

    assign chain_a[0] = tok_entry;

    // Phase A: g^i on lane 0 and g^(r-1) on lane 1, most significant bit first.
    for (genvar j = 0; j < cpcg_pkg::POW_CELLS; j++)
    begin : g_pow
        cpcg_pkg::cell_ctl_t ctl;
        always_comb
        begin
            ctl.sq   = (j % 2 == 0);
            ctl.bit0 = chain_a[j].ebits[7 - j / 2];
            ctl.bit1 = (7 - j / 2 < 3) ? chain_a[j].ebits1[(7 - j / 2) % 3] : 1'b0;
        end
        cpcg_pow_cell u_cell
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .ctl    (ctl),
            .tok_in (chain_a[j]),
            .tok_out(chain_a[j + 1])
        );
    end

    // Select the column element a and the row element y for either mode,
    // then raise a to the inversion exponent.
    always_comb
    begin
        chain_b[0]       = chain_a[cpcg_pkg::POW_CELLS];
        chain_b[0].a     = chain_a[cpcg_pkg::POW_CELLS].mode ?
                           chain_a[cpcg_pkg::POW_CELLS].a : chain_a[cpcg_pkg::POW_CELLS].acc0;
        chain_b[0].y     = chain_a[cpcg_pkg::POW_CELLS].mode ?
                           chain_a[cpcg_pkg::POW_CELLS].y : chain_a[cpcg_pkg::POW_CELLS].acc1;
        chain_b[0].base0 = chain_b[0].a;
        chain_b[0].acc0  = 8'd1;
        chain_b[0].acc1  = 8'd1;
    end

    for (genvar j = 0; j < cpcg_pkg::INV_CELLS; j++)
    begin : g_inv_b
        cpcg_pkg::cell_ctl_t ctl;
        always_comb
        begin
            ctl.sq   = (j % 2 == 0);
            ctl.bit0 = cpcg_pkg::INV_EXP[cpcg_pkg::INV_EXP_BITS - 1 - j / 2];
            ctl.bit1 = 1'b0;
        end
        cpcg_pow_cell u_cell
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .ctl    (ctl),
            .tok_in (chain_b[j]),
            .tok_out(chain_b[j + 1])
        );
    end

    // The power is the inverse only when a times it gives one; a non-unit
    // has inverse zero.
    always_comb
    begin
        x_next      = chain_b[cpcg_pkg::INV_CELLS];
        x_next.base0 = (cpcg_pkg::gf_mul(x_next.poly, x_next.acc0, x_next.a) == 8'd1) ?
                       x_next.acc0 : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
        end
        else if (en)
        begin
            x_reg <= x_next;
        end
    end

    // Phase C: invert (x xor y) on lane 0 and (y xor 1) on lane 1.
    always_comb
    begin
        chain_c[0]       = x_reg;
        chain_c[0].base0 = x_reg.base0 ^ x_reg.y;
        chain_c[0].acc0  = 8'd1;
        chain_c[0].base1 = x_reg.y ^ 8'd1;
        chain_c[0].acc1  = 8'd1;
    end

    for (genvar j = 0; j < cpcg_pkg::INV_CELLS; j++)
    begin : g_inv_c
        cpcg_pkg::cell_ctl_t ctl;
        always_comb
        begin
            ctl.sq   = (j % 2 == 0);
            ctl.bit0 = cpcg_pkg::INV_EXP[cpcg_pkg::INV_EXP_BITS - 1 - j / 2];
            ctl.bit1 = cpcg_pkg::INV_EXP[cpcg_pkg::INV_EXP_BITS - 1 - j / 2];
        end
        cpcg_pow_cell u_cell
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .ctl    (ctl),
            .tok_in (chain_c[j]),
            .tok_out(chain_c[j + 1])
        );
    end

    // Unit checks for both lanes.
    always_comb
    begin
        m_next    = chain_c[cpcg_pkg::INV_CELLS];
        m_next.m0 = cpcg_pkg::gf_mul(m_next.poly, m_next.acc0, m_next.base0);
        m_next.m1 = cpcg_pkg::gf_mul(m_next.poly, m_next.acc1, m_next.base1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= '0;
        end
        else if (en)
        begin
            m_reg <= m_next;
        end
    end

    // The second factor is (y xor 1) itself when it is a unit, else zero.
    always_comb
    begin
        e_val = (m_reg.m0 == 8'd1) ? m_reg.acc0 : 8'd0;
        f_val = (m_reg.m1 == 8'd1) ? m_reg.base1 : 8'd0;
        priority if (!m_reg.rng)
        begin
            coef_next = 8'd0;
        end
        else if (m_reg.row == 3'd0)
        begin
            coef_next = 8'd1;
        end
        else if (m_reg.row == 3'd1)
        begin
            coef_next = m_reg.a;
        end
        else
        begin
            coef_next = cpcg_pkg::gf_mul(m_reg.poly, e_val, f_val);
        end
    end

    // Output register: holds its result until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= m_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef_reg <= coef_next;
            rng_reg  <= m_reg.rng;
        end
    end

    assign out_valid   = out_vld_reg;
    assign coefficient = coef_reg;
    assign in_range    = rng_reg;

endmodule

/* verif/tb_cauchy_parity_coefficient_gen_core.sv */
// ----------------------------------------------------------------------------
// tb_cauchy_parity_coefficient_gen_core: self-checking bench for the core
// Sends (row, disk) transactions through several register settings, takes each expected
// coefficient from the directed table or predicts it in GF(2^8), and checks each result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_cauchy_parity_coefficient_gen_core;

    // The drain wait is sized from the chain latency of the core.
    localparam int LATENCY    = 131;
    localparam int DRAIN_WAIT = LATENCY + 20;
    localparam int WATCHDOG   = 4000;

    typedef struct {
        logic [7:0] coef;
        logic       rng;
    } coef_t;

    // One row of the directed table. When has_exp is set the expected result
    // is typed in here; otherwise it comes from the predictor.
    typedef struct {
        logic [2:0] row;
        logic [7:0] disk;
        logic       has_exp;
        logic [7:0] exp_coef;
        logic       exp_rng;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] parity_row;
    logic [7:0] disk_index;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] coefficient;
    logic       in_range;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    // Shadow copy of the configuration registers.
    logic       mode_q;
    logic [7:0] poly_q;
    logic [7:0] gen_q;

    coef_t      pending_q[$];
    int         n_err;
    int         n_idle;
    bit         calm;        // no idling in the last part of the run
    bit         finished;

    cauchy_parity_coefficient_gen_core u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .parity_row  (parity_row),
        .disk_index  (disk_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .coefficient (coefficient),
        .in_range    (in_range),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // Field arithmetic for the predictor.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] fmul(input logic [7:0] p, input logic [7:0] a,
                                        input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'd0;
        x   = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                acc ^= x;
            end
            x = x[7] ? ({x[6:0], 1'b0} ^ p) : {x[6:0], 1'b0};
        end
        return acc;
    endfunction

    // The largest b with a*b = 1, or 0 when a has no inverse (reducible
    // polynomial) or is zero.
    function automatic logic [7:0] finv(input logic [7:0] p, input logic [7:0] a);
        logic [7:0] res;
        res = 8'd0;
        for (int b = 1; b < 256; b++)
        begin
            if (fmul(p, a, b[7:0]) == 8'd1)
            begin
                res = b[7:0];
            end
        end
        return res;
    endfunction

    function automatic logic [7:0] fpow(input logic [7:0] p, input logic [7:0] g,
                                        input int n);
        logic [7:0] v;
        v = 8'd1;
        for (int k = 0; k < n; k++)
        begin
            v = fmul(p, g, v);
        end
        return v;
    endfunction

    // Element k of the AES G23 sequence: doubling, with a tripling after
    // steps 50, 101, 152 and 203.
    function automatic logic [7:0] g23_elem(input int k);
        logic [7:0] v;
        v = 8'd1;
        for (int j = 0; j < k; j++)
        begin
            v = fmul(cpcg_pkg::AES_POLY, (j == 50 || j == 101 || j == 152 || j == 203) ?
                     8'd3 : 8'd2, v);
        end
        return v;
    endfunction

    function automatic coef_t cauchy_coef(input logic [2:0] row, input logic [7:0] disk);
        coef_t      res;
        logic [7:0] gi;
        logic [7:0] y;
        logic [7:0] x;
        logic [7:0] e;
        logic [7:0] f;
        res.coef = 8'd0;
        res.rng  = 1'b0;
        if (row >= cpcg_pkg::PARITY_ROWS || disk >= cpcg_pkg::DISK_COUNT)
        begin
            return res;
        end
        res.rng = 1'b1;
        if (row == 3'd0)
        begin
            res.coef = 8'd1;
        end
        else if (mode_q)
        begin
            x = finv(cpcg_pkg::AES_POLY, g23_elem(disk % 255));
            if (row == 3'd1)
            begin
                res.coef = finv(cpcg_pkg::AES_POLY, x);
            end
            else
            begin
                y = finv(cpcg_pkg::AES_POLY, g23_elem((255 - (row - 1)) % 255));
                e = finv(cpcg_pkg::AES_POLY, x ^ y);
                f = finv(cpcg_pkg::AES_POLY, finv(cpcg_pkg::AES_POLY, 8'd1 ^ y));
                res.coef = fmul(cpcg_pkg::AES_POLY, e, f);
            end
        end
        else
        begin
            gi = fpow(poly_q, gen_q, disk);
            if (row == 3'd1)
            begin
                res.coef = gi;
            end
            else
            begin
                y = fpow(poly_q, gen_q, row - 1);
                e = finv(poly_q, y ^ finv(poly_q, gi));
                f = finv(poly_q, finv(poly_q, y ^ 8'd1));
                res.coef = fmul(poly_q, e, f);
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, then an in-order check.
    // ------------------------------------------------------------------------
    initial
    begin
        int burst;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && burst == 0 && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 4);
            end
            out_stall <= (burst > 0) && !calm;
            if (burst > 0)
            begin
                burst--;
            end
        end
    end

    always @(posedge clk)
    begin
        coef_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                begin
                    $display("unexpected result: coefficient %h in_range %b",
                             coefficient, in_range);
                end
            end
            else
            begin
                want = pending_q.pop_front();
                if (coefficient !== want.coef || in_range !== want.rng)
                begin
                    n_err++;
                    if (n_err <= 10)
                    begin
                        $display("mismatch: expected coefficient %h in_range %b, got %h %b",
                                 want.coef, want.rng, coefficient, in_range);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which no transaction is accepted on either
    // channel. A drained, quiet bench is not counted.
    always @(posedge clk)
    begin
        if (!rst_n || finished || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (!in_valid && pending_q.size() == 0))
        begin
            n_idle <= 0;
        end
        else
        begin
            n_idle <= n_idle + 1;
            if (n_idle >= WATCHDOG)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side.
    // ------------------------------------------------------------------------
    // Drives one transaction, with an optional idle burst in front, and
    // records its expected result once the core has taken it.
    task automatic send_req(input logic [2:0] row, input logic [7:0] disk,
                            input logic has_exp, input logic [7:0] exp_coef,
                            input logic exp_rng);
        coef_t want;
        int    gap;
        gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        parity_row <= row;
        disk_index <= disk;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        if (has_exp)
        begin
            want.coef = exp_coef;
            want.rng  = exp_rng;
        end
        else
        begin
            want = cauchy_coef(row, disk);
        end
        pending_q.push_back(want);
    endtask

    // Waits for every outstanding result and then the chain latency, so the
    // core is idle before a register write.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Raises the write enable and drops it again before returning, so back-to-back writes
    // never drive the enable twice in one time step.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            cpcg_pkg::CFG_MATRIX_MODE:    mode_q = val[0];
            cpcg_pkg::CFG_REDUCTION_POLY: poly_q = val;
            cpcg_pkg::CFG_GENERATOR:      gen_q  = val;
            default:                      ;
        endcase
        @(posedge clk);
    endtask

    // A phase of random transactions. Most land in range; a share exercises
    // the out-of-range rows and disk indexes, and every bit of both fields.
    task automatic random_phase(input int count);
        logic [2:0] row;
        logic [7:0] disk;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                row  = 3'($urandom_range(0, 7));
                disk = 8'($urandom_range(0, 255));
            end
            else
            begin
                row  = 3'($urandom_range(0, cpcg_pkg::PARITY_ROWS - 1));
                disk = 8'($urandom_range(0, cpcg_pkg::DISK_COUNT - 1));
            end
            send_req(row, disk, 1'b0, 8'd0, 1'b0);
        end
    endtask

    dir_row_t dir_tab[] = '{
        '{3'd0, 8'd0,   1'b1, 8'd1, 1'b1},     // row zero is all ones
        '{3'd0, 8'd250, 1'b1, 8'd1, 1'b1},     // last valid disk
        '{3'd1, 8'd0,   1'b1, 8'd1, 1'b1},     // g^0
        '{3'd1, 8'd1,   1'b1, 8'd2, 1'b1},     // g^1 at reset
        '{3'd5, 8'd251, 1'b1, 8'd0, 1'b0},     // first disk out of range
        '{3'd6, 8'd0,   1'b1, 8'd0, 1'b0},     // first row out of range
        '{3'd7, 8'd255, 1'b1, 8'd0, 1'b0},     // both fields at their top
        '{3'd2, 8'd0,   1'b0, 8'd0, 1'b0},
        '{3'd2, 8'd1,   1'b0, 8'd0, 1'b0},
        '{3'd3, 8'd100, 1'b0, 8'd0, 1'b0},
        '{3'd4, 8'd200, 1'b0, 8'd0, 1'b0},
        '{3'd5, 8'd250, 1'b0, 8'd0, 1'b0},
        '{3'd1, 8'd250, 1'b0, 8'd0, 1'b0},
        '{3'd5, 8'd4,   1'b0, 8'd0, 1'b0}
    };

    initial
    begin
        in_valid   = 1'b0;
        parity_row = 3'd0;
        disk_index = 8'd0;
        cfg_we     = 1'b0;
        cfg_index  = cpcg_pkg::CFG_MATRIX_MODE;
        cfg_data   = 8'd0;
        calm       = 1'b0;
        finished   = 1'b0;
        mode_q     = 1'b0;
        poly_q     = cpcg_pkg::RESET_POLY;
        gen_q      = cpcg_pkg::RESET_GEN;
        rst_n      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset configuration.
        foreach (dir_tab[k])
        begin
            send_req(dir_tab[k].row, dir_tab[k].disk, dir_tab[k].has_exp,
                     dir_tab[k].exp_coef, dir_tab[k].exp_rng);
        end
        random_phase(180);

        // AES construction; one disk index hits a tripling point of the sequence.
        drain();
        write_reg(cpcg_pkg::CFG_MATRIX_MODE, 8'd1);
        send_req(3'd1, 8'd0, 1'b1, 8'd1, 1'b1);
        send_req(3'd1, 8'd51, 1'b0, 8'd0, 1'b0);
        send_req(3'd5, 8'd250, 1'b0, 8'd0, 1'b0);
        random_phase(180);

        // RAID mode with extreme polynomial and generator values, including
        // a reducible polynomial where some inverses do not exist.
        drain();
        write_reg(cpcg_pkg::CFG_MATRIX_MODE, 8'd0);
        write_reg(cpcg_pkg::CFG_REDUCTION_POLY, 8'hff);
        write_reg(cpcg_pkg::CFG_GENERATOR, 8'hff);
        random_phase(120);

        drain();
        write_reg(cpcg_pkg::CFG_REDUCTION_POLY, 8'h00);
        write_reg(cpcg_pkg::CFG_GENERATOR, 8'h01);
        random_phase(100);

        drain();
        write_reg(cpcg_pkg::CFG_REDUCTION_POLY, 8'h1b);
        write_reg(cpcg_pkg::CFG_GENERATOR, 8'h03);
        random_phase(120);

        // Random polynomial and generator settings.
        drain();
        write_reg(cpcg_pkg::CFG_REDUCTION_POLY, 8'($urandom_range(0, 255)));
        write_reg(cpcg_pkg::CFG_GENERATOR, 8'($urandom_range(0, 255)));
        random_phase(100);

        // Last part in AES mode with no idling on either side.
        drain();
        write_reg(cpcg_pkg::CFG_MATRIX_MODE, 8'd1);
        calm = 1'b1;
        random_phase(133);

        in_valid <= 1'b0;
        while (pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        finished = 1'b1;
        if (n_err == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
